// ===== src/gei_pkg.sv =====
package gei_pkg;

  // Number of implemented pins; bus fields stay 32 bits wide.
  localparam int unsigned WIDTH = 32;
  localparam int unsigned BUS_W = 32;

  localparam logic [BUS_W-1:0] VALID_MASK = BUS_W'((64'd1 << WIDTH) - 64'd1);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [2:0] ADDR_DIR     = 3'd0;
  localparam logic [2:0] ADDR_OUT     = 3'd1;
  localparam logic [2:0] ADDR_IN      = 3'd2;
  localparam logic [2:0] ADDR_IRQ_EN  = 3'd3;
  localparam logic [2:0] ADDR_PENDING = 3'd4;

  localparam logic [1:0] RESP_OK       = 2'd0;
  localparam logic [1:0] RESP_CMD_ERR  = 2'd1;
  localparam logic [1:0] RESP_ADDR_ERR = 2'd2;

  typedef logic [WIDTH-1:0] pin_vec_t;

  typedef struct packed {
    logic [BUS_W-1:0] rdata;
    logic [1:0]       resp;
    logic [BUS_W-1:0] pin_out;
    logic [BUS_W-1:0] pin_oe;
    logic             irq;
  } result_t;

endpackage

// ===== src/gei_if.sv =====
interface gei_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  address;
  logic [31:0] wdata;
  logic [31:0] pins;

  modport source (output valid, output op, output address, output wdata, output pins,
                  input ready);
  modport sink   (input valid, input op, input address, input wdata, input pins,
                  output ready);
endinterface

interface gei_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic [1:0]  resp;
  logic [31:0] pin_out;
  logic [31:0] pin_oe;
  logic        irq;

  modport source (output valid, output rdata, output resp, output pin_out, output pin_oe,
                  output irq, input ready);
  modport sink   (input valid, input rdata, input resp, input pin_out, input pin_oe,
                  input irq, output ready);
endinterface

// ===== src/gpio_edge_irq_registers_top.sv =====
// GPIO bank with rising-edge interrupt capture and a five-register file
// (0 direction, 1 output, 2 input, 3 irq enable, 4 pending, write one to
// clear). Every input beat carries the pin levels plus a tick, read or
// write; each beat yields exactly one result beat. Throughput is one beat
// per clock unless the output buffer is full: all of the work is a single
// level of bitwise logic and a register select feeding the output register
// (or the skid register when that is stalled or the skid is occupied).
// A two-entry output buffer (output register plus skid register) lets
// in_ch.ready stay high through a stall of the sink; ready drops only once
// both are full. The first beat after reset primes the edge detector.
module gpio_edge_irq_registers_top (
  input  logic      clk,
  input  logic      rst_n,
  gei_in_if.sink    in_ch,
  gei_out_if.source out_ch
);
  import gei_pkg::*;

  // architectural state
  pin_vec_t dir_r, dir_nxt;
  pin_vec_t outv_r, outv_nxt;
  pin_vec_t irq_en_r, irq_en_nxt;
  pin_vec_t pend_r, pend_nxt;
  pin_vec_t prev_r, prev_nxt;
  logic     primed_r;

  // output buffer
  result_t  res_r, skid_r, res_nxt;
  logic     res_vld_r, skid_vld_r;

  logic     in_fire, out_fire;
  pin_vec_t pins_w, wdata_w, level, edges, pend_edge;
  logic     wdata_bad;

  assign in_ch.ready = !skid_vld_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  assign pins_w    = in_ch.pins[WIDTH-1:0];
  assign wdata_w   = in_ch.wdata[WIDTH-1:0];
  assign wdata_bad = (in_ch.wdata & ~VALID_MASK) != '0;

  // sample inputs: driven pins are masked out of the edge detector
  assign level     = pins_w & ~dir_r;
  assign edges     = primed_r ? (level & ~prev_r) : '0;
  assign pend_edge = pend_r | edges;

  always_comb begin
    dir_nxt    = dir_r;
    outv_nxt   = outv_r;
    irq_en_nxt = irq_en_r;
    pend_nxt   = pend_edge;
    prev_nxt   = level;
    res_nxt.rdata = '0;
    res_nxt.resp  = RESP_OK;

    if (in_ch.op == OP_WRITE) begin
      if (wdata_bad) begin
        res_nxt.resp = RESP_CMD_ERR;
      end else begin
        unique case (in_ch.address)
          ADDR_DIR: begin
            dir_nxt  = wdata_w;
            // re-capture so the direction change raises no edge
            prev_nxt = pins_w & ~wdata_w;
          end
          ADDR_OUT:     outv_nxt   = wdata_w;
          ADDR_IN:      res_nxt.resp = RESP_CMD_ERR;
          ADDR_IRQ_EN:  irq_en_nxt = wdata_w;
          ADDR_PENDING: pend_nxt   = (pend_edge & ~wdata_w) | edges;
          default:      res_nxt.resp = RESP_ADDR_ERR;
        endcase
      end
    end else if (in_ch.op == OP_READ) begin
      unique case (in_ch.address)
        ADDR_DIR:     res_nxt.rdata = BUS_W'(dir_r);
        ADDR_OUT:     res_nxt.rdata = BUS_W'(outv_r);
        ADDR_IN:      res_nxt.rdata = BUS_W'(level);
        ADDR_IRQ_EN:  res_nxt.rdata = BUS_W'(irq_en_r);
        ADDR_PENDING: res_nxt.rdata = BUS_W'(pend_edge);
        default:      res_nxt.resp  = RESP_ADDR_ERR;
      endcase
    end

    // status reflects the registers after this beat
    res_nxt.pin_out = BUS_W'(outv_nxt & dir_nxt);
    res_nxt.pin_oe  = BUS_W'(dir_nxt);
    res_nxt.irq     = (pend_nxt & irq_en_nxt) != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= '0;
      outv_r   <= '0;
      irq_en_r <= '0;
      pend_r   <= '0;
      prev_r   <= '0;
      primed_r <= 1'b0;
    end else if (in_fire) begin
      dir_r    <= dir_nxt;
      outv_r   <= outv_nxt;
      irq_en_r <= irq_en_nxt;
      pend_r   <= pend_nxt;
      prev_r   <= prev_nxt;
      primed_r <= 1'b1;
    end
  end

  // output register with skid: a new beat goes to the output register when
  // it is free or draining and the skid is empty, else into the skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!res_vld_r || out_fire) begin
        if (skid_vld_r) begin
          res_vld_r  <= 1'b1;
          skid_vld_r <= in_fire;
        end else begin
          res_vld_r  <= in_fire;
        end
      end else if (in_fire) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!res_vld_r || out_fire) begin
      if (skid_vld_r) begin
        res_r <= skid_r;
        if (in_fire) begin
          skid_r <= res_nxt;
        end
      end else if (in_fire) begin
        res_r <= res_nxt;
      end
    end else if (in_fire) begin
      skid_r <= res_nxt;
    end
  end

  assign out_ch.valid   = res_vld_r;
  assign out_ch.rdata   = res_r.rdata;
  assign out_ch.resp    = res_r.resp;
  assign out_ch.pin_out = res_r.pin_out;
  assign out_ch.pin_oe  = res_r.pin_oe;
  assign out_ch.irq     = res_r.irq;

endmodule

// ===== src/gei_checker.sv =====
module gei_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_resp,
  input logic [31:0] out_pin_out,
  input logic [31:0] out_pin_oe
);
  import gei_pkg::*;

  // stalled result beat is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_resp) && $stable(out_pin_oe))
    else $error("result beat changed while stalled");

  // driven levels only on enabled pins
  a_drive_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pin_out & ~out_pin_oe) == '0)
    else $error("pin_out set on a pin that is not driven");

  a_resp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_resp == RESP_OK || out_resp == RESP_CMD_ERR ||
                   out_resp == RESP_ADDR_ERR))
    else $error("unknown response code");

  // ready drops only when both buffer entries hold a beat
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("buffer not empty after reset");

endmodule

bind gpio_edge_irq_registers_top gei_checker u_gei_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_resp    (out_ch.resp),
  .out_pin_out (out_ch.pin_out),
  .out_pin_oe  (out_ch.pin_oe)
);
